/* design/diff_drive_setpoint_shaper_top_macros.svh */
// Assertion macros for the setpoint shaper checkers.
// Uses clk and rst of the module that expands them.
`ifndef DIFF_DRIVE_SETPOINT_SHAPER_TOP_MACROS_SVH
`define DIFF_DRIVE_SETPOINT_SHAPER_TOP_MACROS_SVH
// checked outside reset only
`define DDS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define DDS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* design/dds_pkg.sv */
// Shared types and constants for the differential drive setpoint shaper.
// No dependencies.
`default_nettype none
package dds_pkg;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int RATIO_W  = RATIO_FRAC_BITS + 1;
  localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

  localparam int SPEED_W  = 24;
  localparam int RADIUS_W = 25;
  localparam int MAG_W    = RADIUS_W + 1;   // |curve + correction|
  localparam int OFS_W    = 10;
  localparam int LIM_W    = 23;
  localparam int MAXR_W   = 24;
  localparam int DEN_W    = 25;             // divisor / numerator magnitude
  localparam int NUM_W    = DEN_W + RATIO_FRAC_BITS;
  localparam int QUO_W    = NUM_W + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MID_DEPTH  = 2;
  localparam int MID_PTR_W  = $clog2(MID_DEPTH);

  localparam logic [LIM_W-1:0]  RST_MAX_TRANS       = 23'd1000;
  localparam logic [LIM_W-1:0]  RST_MAX_WHEEL       = 23'd1300;
  localparam logic [LIM_W-1:0]  RST_ACCEL_STEP      = 23'd50;
  localparam logic [LIM_W-1:0]  RST_MAX_DECEL       = 23'd50;
  localparam logic [OFS_W-1:0]  RST_OFFSET          = 10'd100;
  localparam logic [MAXR_W-1:0] RST_STRAIGHT_RADIUS = 24'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_TRANS       = 3'd0,
    CFG_MAX_WHEEL       = 3'd1,
    CFG_ACCEL_STEP      = 3'd2,
    CFG_MAX_DECEL       = 3'd3,
    CFG_LEFT_OFS        = 3'd4,
    CFG_RIGHT_OFS       = 3'd5,
    CFG_STRAIGHT_RADIUS = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [LIM_W-1:0]  max_trans;
    logic [LIM_W-1:0]  max_wheel;
    logic [LIM_W-1:0]  accel_step;
    logic [LIM_W-1:0]  max_decel;
    logic [OFS_W-1:0]  left_offset;
    logic [OFS_W-1:0]  right_offset;
    logic [MAXR_W-1:0] straight_radius;
  } cfg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic [RATIO_W-1:0]        left_ratio;
    logic [RATIO_W-1:0]        right_ratio;
  } mid_item_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SETUP, F_DIV, F_MAX, F_ADJ, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_CLAMP, B_MUL, B_WHEEL, B_DIFF, B_SLEW, B_OUT
  } back_state_t;
endpackage
`default_nettype wire

/* design/dds_div.sv */
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on dds_pkg.
`default_nettype none
module dds_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [dds_pkg::NUM_W-1:0] num,
  input  wire logic [dds_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic [dds_pkg::NUM_W-1:0]      quo
);
  import dds_pkg::*;

  logic [DEN_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       trial_sub;
  logic                 fits;

  assign trial     = {rem, quo[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den};
  assign fits      = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DIV_CNT_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (run) begin
      rem <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end
endmodule
`default_nettype wire

/* design/dds_front.sv */
// Front end: accepts commands and computes both wheel ratios (Q1.F).
// Depends on dds_pkg and dds_div.
`default_nettype none
module dds_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire dds_pkg::cfg_t                       cfg,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [dds_pkg::SPEED_W-1:0]  speed_command,
  input  wire logic signed [dds_pkg::RADIUS_W-1:0] curve_radius,
  input  wire logic signed [dds_pkg::RADIUS_W-1:0] radius_correction,
  input  wire logic                                mid_full,
  output logic                                     mid_push,
  output dds_pkg::mid_item_t                       mid_item
);
  import dds_pkg::*;

  localparam int WIDE = MAG_W + 2;
  localparam logic signed [QUO_W-1:0] ONE_Q = {{(QUO_W-RATIO_W){1'b0}}, RATIO_ONE};

  front_state_t state, state_next;

  logic signed [SPEED_W-1:0] speed;
  logic [MAG_W-1:0]          r;
  logic                      neg;
  logic                      sign_l, sign_r;
  logic signed [QUO_W-1:0]   lq, rq, excess;
  logic                      over;
  logic [RATIO_W-1:0]        ratio_l, ratio_r;

  // accept: effective radius
  logic signed [RADIUS_W:0] s_sum;
  logic [MAG_W-1:0]         r_next;
  assign s_sum  = {curve_radius[RADIUS_W-1], curve_radius}
                + {radius_correction[RADIUS_W-1], radius_correction};
  assign r_next = s_sum[RADIUS_W] ? MAG_W'(-s_sum) : MAG_W'(s_sum);

  // setup: numerators and denominator
  logic signed [WIDE-1:0] rs, lo_s, ro_s, dd, nl, nr, nl_abs, nr_abs, dd_abs;
  logic                   curved, d_zero, div_start;
  assign rs     = $signed({2'b00, r});
  assign lo_s   = $signed({{(WIDE-OFS_W){1'b0}}, cfg.left_offset});
  assign ro_s   = $signed({{(WIDE-OFS_W){1'b0}}, cfg.right_offset});
  assign dd     = rs + ro_s - lo_s;
  assign nl     = neg ? rs + lo_s : rs - lo_s;
  assign nr     = neg ? rs - ro_s : rs + ro_s;
  assign nl_abs = nl[WIDE-1] ? -nl : nl;
  assign nr_abs = nr[WIDE-1] ? -nr : nr;
  assign dd_abs = dd[WIDE-1] ? -dd : dd;
  assign curved = r < {{(MAG_W-MAXR_W){1'b0}}, cfg.straight_radius};
  assign d_zero = dd == '0;

  logic [NUM_W-1:0] num_l, num_r, quo_l, quo_r;
  logic             done_l, done_r, div_done;
  assign num_l = {nl_abs[DEN_W-1:0], {RATIO_FRAC_BITS{1'b0}}};
  assign num_r = {nr_abs[DEN_W-1:0], {RATIO_FRAC_BITS{1'b0}}};
  assign div_done = done_l && done_r;

  dds_div u_div_l (
    .clk(clk), .rst(rst), .start(div_start), .num(num_l),
    .den(dd_abs[DEN_W-1:0]), .done(done_l), .quo(quo_l)
  );
  dds_div u_div_r (
    .clk(clk), .rst(rst), .start(div_start), .num(num_r),
    .den(dd_abs[DEN_W-1:0]), .done(done_r), .quo(quo_r)
  );

  logic signed [QUO_W-1:0] ql_abs, qr_abs, mx;
  logic signed [QUO_W:0]   la, ra, ex_w;
  assign ql_abs = $signed({1'b0, quo_l});
  assign qr_abs = $signed({1'b0, quo_r});
  assign mx     = (lq > rq) ? lq : rq;
  assign ex_w   = over ? {excess[QUO_W-1], excess} : '0;
  assign la     = {lq[QUO_W-1], lq} - ex_w;
  assign ra     = {rq[QUO_W-1], rq} - ex_w;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (push) state_next = F_SETUP;
      F_SETUP: state_next = (curved && !d_zero) ? F_DIV : F_MAX;
      F_DIV:   if (div_done) state_next = F_MAX;
      F_MAX:   state_next = F_ADJ;
      F_ADJ:   state_next = F_PUSH;
      F_PUSH:  if (!mid_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full      = state != F_IDLE;
    div_start = (state == F_SETUP) && curved && !d_zero;
    mid_push  = (state == F_PUSH) && !mid_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        speed <= speed_command;
        r     <= r_next;
        neg   <= curve_radius[RADIUS_W-1];
      end
      F_SETUP: begin
        sign_l <= nl[WIDE-1] ^ dd[WIDE-1];
        sign_r <= nr[WIDE-1] ^ dd[WIDE-1];
        lq     <= ONE_Q;
        rq     <= ONE_Q;
      end
      F_DIV: begin
        if (div_done) begin
          lq <= sign_l ? -ql_abs : ql_abs;
          rq <= sign_r ? -qr_abs : qr_abs;
        end
      end
      F_MAX: begin
        over   <= mx > ONE_Q;
        excess <= mx - ONE_Q;
      end
      F_ADJ: begin
        ratio_l <= la[QUO_W] ? '0 : la[RATIO_W-1:0];
        ratio_r <= ra[QUO_W] ? '0 : ra[RATIO_W-1:0];
      end
      default: ;
    endcase
  end

  assign mid_item.speed       = speed;
  assign mid_item.left_ratio  = ratio_l;
  assign mid_item.right_ratio = ratio_r;
endmodule
`default_nettype wire

/* design/dds_fifo.sv */
// Two-entry queue between the ratio front end and the wheel back end.
// Depends on dds_pkg.
`default_nettype none
module dds_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire dds_pkg::mid_item_t wdata,
  output logic                    full,
  input  wire logic               pop,
  output dds_pkg::mid_item_t      rdata,
  output logic                    empty
);
  import dds_pkg::*;

  mid_item_t            slots [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [MID_PTR_W:0]   count;

  assign full  = count == (MID_PTR_W+1)'(MID_DEPTH);
  assign empty = count == '0;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + (MID_PTR_W+1)'(1);
      else if (pop && !push) count <= count - (MID_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end
endmodule
`default_nettype wire

/* design/dds_back.sv */
// Back end: speed clamp, ratio scaling, wheel clamp and slew limit, one wheel
// at a time, plus the result register. Depends on dds_pkg.
`default_nettype none
module dds_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire dds_pkg::cfg_t                      cfg,
  input  wire logic                               mid_empty,
  output logic                                    mid_pop,
  input  wire dds_pkg::mid_item_t                 mid_item,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic signed [dds_pkg::SPEED_W-1:0]      left_setpoint,
  output logic signed [dds_pkg::SPEED_W-1:0]      right_setpoint,
  output logic [dds_pkg::RATIO_W-1:0]             left_ratio,
  output logic [dds_pkg::RATIO_W-1:0]             right_ratio
);
  import dds_pkg::*;

  localparam int P_W = SPEED_W + RATIO_W + 1;
  localparam int A_W = LIM_W + RATIO_W;
  localparam int S_W = A_W + 2;
  localparam int C_W = SPEED_W + 1;
  localparam logic [RATIO_FRAC_BITS-1:0] RND = '1;

  back_state_t state, state_next;

  mid_item_t                 item;
  logic                      wsel, out_valid;
  logic signed [SPEED_W-1:0] v, w, res_l, last_l, last_r;
  logic signed [P_W-1:0]     pv;
  logic [A_W-1:0]            pa, pd;
  logic                      up, dn;
  logic signed [S_W-1:0]     sa, sd;

  logic [RATIO_W-1:0]        ratio;
  logic signed [SPEED_W-1:0] last;
  assign ratio = wsel ? item.right_ratio : item.left_ratio;
  assign last  = wsel ? last_r : last_l;

  // translation clamp
  logic signed [C_W-1:0] sp_w, mts_p, mts_n, v_next;
  assign sp_w   = {item.speed[SPEED_W-1], item.speed};
  assign mts_p  = $signed({2'b00, cfg.max_trans});
  assign mts_n  = -mts_p;
  assign v_next = (sp_w > mts_p) ? mts_p : (sp_w < mts_n) ? mts_n : sp_w;

  // scaled speed, truncated toward zero, then wheel clamp
  logic signed [P_W-1:0] pv_adj;
  logic signed [C_W-1:0] wq, mws_p, mws_n, w_next;
  assign pv_adj = pv + (pv[P_W-1] ? $signed({{(P_W-RATIO_FRAC_BITS){1'b0}}, RND}) : '0);
  assign wq     = pv_adj[RATIO_FRAC_BITS +: C_W];
  assign mws_p  = $signed({2'b00, cfg.max_wheel});
  assign mws_n  = -mws_p;
  assign w_next = (wq > mws_p) ? mws_p : (wq < mws_n) ? mws_n : wq;

  // slew check
  logic signed [C_W-1:0] diff;
  logic signed [S_W-1:0] base;
  assign diff = {w[SPEED_W-1], w} - {last[SPEED_W-1], last};
  assign base = {{(S_W-SPEED_W-RATIO_FRAC_BITS){last[SPEED_W-1]}}, last,
                 {RATIO_FRAC_BITS{1'b0}}};

  logic signed [S_W-1:0]     sa_adj, sd_adj;
  logic signed [SPEED_W-1:0] nw;
  assign sa_adj = sa + (sa[S_W-1] ? $signed({{(S_W-RATIO_FRAC_BITS){1'b0}}, RND}) : '0);
  assign sd_adj = sd + (sd[S_W-1] ? $signed({{(S_W-RATIO_FRAC_BITS){1'b0}}, RND}) : '0);
  assign nw = up ? sa_adj[RATIO_FRAC_BITS +: SPEED_W]
            : dn ? sd_adj[RATIO_FRAC_BITS +: SPEED_W] : w;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!mid_empty) state_next = B_CLAMP;
      B_CLAMP: state_next = B_MUL;
      B_MUL:   state_next = B_WHEEL;
      B_WHEEL: state_next = B_DIFF;
      B_DIFF:  state_next = B_SLEW;
      B_SLEW:  state_next = wsel ? B_OUT : B_MUL;
      B_OUT:   if (!out_valid) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    mid_pop = (state == B_IDLE) && !mid_empty;
    empty   = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      wsel      <= 1'b0;
      last_l    <= '0;
      last_r    <= '0;
    end else begin
      state <= state_next;
      if (state == B_IDLE) wsel <= 1'b0;
      if (state == B_SLEW) wsel <= 1'b1;
      if (state == B_OUT && !out_valid) begin
        out_valid <= 1'b1;
        last_l    <= res_l;
        last_r    <= w;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE:  item <= mid_item;
      B_CLAMP: v <= v_next[SPEED_W-1:0];
      B_MUL: begin
        pv <= $signed(v) * $signed({1'b0, ratio});
        pa <= A_W'(cfg.accel_step * ratio);
        pd <= A_W'(cfg.max_decel * ratio);
      end
      B_WHEEL: w <= w_next[SPEED_W-1:0];
      B_DIFF: begin
        up <= diff > $signed({2'b00, cfg.accel_step});
        dn <= diff < -$signed({2'b00, cfg.max_decel});
        sa <= base + $signed({2'b00, pa});
        sd <= base - $signed({2'b00, pd});
      end
      B_SLEW: begin
        // left result parks in res_l; right stays in w until the result write
        if (!wsel) res_l <= nw;
        else w <= nw;
      end
      B_OUT: begin
        if (!out_valid) begin
          left_setpoint  <= res_l;
          right_setpoint <= w;
          left_ratio     <= item.left_ratio;
          right_ratio    <= item.right_ratio;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* design/diff_drive_setpoint_shaper_top.sv */
// Differential drive setpoint shaper, top level.
// Steps from accept to result with no stalls (setup, 41-step serial
// division of 25+F bits plus done, max, adjust, queue push, wheel sequencer pass per wheel).
// The front end stays full from accept until its item is pushed into the queue.
// Reset (rst, synchronous): registers to defaults, previous setpoints zero, queues empty.
`default_nettype none
module diff_drive_setpoint_shaper_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // command side
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [dds_pkg::SPEED_W-1:0]  speed_command,
  input  wire logic signed [dds_pkg::RADIUS_W-1:0] curve_radius,
  input  wire logic signed [dds_pkg::RADIUS_W-1:0] radius_correction,
  // result side
  output logic                                     empty,
  input  wire logic                                pop,
  output logic signed [dds_pkg::SPEED_W-1:0]       left_setpoint,
  output logic signed [dds_pkg::SPEED_W-1:0]       right_setpoint,
  output logic [dds_pkg::RATIO_W-1:0]              left_ratio,
  output logic [dds_pkg::RATIO_W-1:0]              right_ratio,
  // register writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dds_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dds_pkg::*;

  cfg_t      cfg;
  mid_item_t mid_wdata, mid_rdata;
  logic      mid_push, mid_full, mid_pop, mid_empty;

  // writes always complete; indexes past the last register are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_trans       <= RST_MAX_TRANS;
      cfg.max_wheel       <= RST_MAX_WHEEL;
      cfg.accel_step      <= RST_ACCEL_STEP;
      cfg.max_decel       <= RST_MAX_DECEL;
      cfg.left_offset     <= RST_OFFSET;
      cfg.right_offset    <= RST_OFFSET;
      cfg.straight_radius <= RST_STRAIGHT_RADIUS;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAX_TRANS:       cfg.max_trans       <= cfg_data[LIM_W-1:0];
        CFG_MAX_WHEEL:       cfg.max_wheel       <= cfg_data[LIM_W-1:0];
        CFG_ACCEL_STEP:      cfg.accel_step      <= cfg_data[LIM_W-1:0];
        CFG_MAX_DECEL:       cfg.max_decel       <= cfg_data[LIM_W-1:0];
        CFG_LEFT_OFS:        cfg.left_offset     <= cfg_data[OFS_W-1:0];
        CFG_RIGHT_OFS:       cfg.right_offset    <= cfg_data[OFS_W-1:0];
        CFG_STRAIGHT_RADIUS: cfg.straight_radius <= cfg_data[MAXR_W-1:0];
        default: ;
      endcase
    end
  end

  // front: radius, offsets and the two ratio divisions
  dds_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .push(push), .full(full),
    .speed_command(speed_command), .curve_radius(curve_radius),
    .radius_correction(radius_correction),
    .mid_full(mid_full), .mid_push(mid_push), .mid_item(mid_wdata)
  );

  // decouples ratio work from wheel shaping
  dds_fifo u_mid (
    .clk(clk), .rst(rst),
    .push(mid_push), .wdata(mid_wdata), .full(mid_full),
    .pop(mid_pop), .rdata(mid_rdata), .empty(mid_empty)
  );

  // back: clamps, products, slew limit, result register and wheel history
  dds_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .mid_empty(mid_empty), .mid_pop(mid_pop), .mid_item(mid_rdata),
    .empty(empty), .pop(pop),
    .left_setpoint(left_setpoint), .right_setpoint(right_setpoint),
    .left_ratio(left_ratio), .right_ratio(right_ratio)
  );
endmodule
`default_nettype wire

/* design/dds_checker.sv */
// Port-level checks for the setpoint shaper, bound to the top level.
// Depends on dds_pkg and the assertion macro header.
`default_nettype none
`include "diff_drive_setpoint_shaper_top_macros.svh"
module dds_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               push,
  input wire logic                               full,
  input wire logic                               pop,
  input wire logic                               empty,
  input wire logic signed [dds_pkg::SPEED_W-1:0] left_setpoint,
  input wire logic signed [dds_pkg::SPEED_W-1:0] right_setpoint,
  input wire logic [dds_pkg::RATIO_W-1:0]        left_ratio,
  input wire logic [dds_pkg::RATIO_W-1:0]        right_ratio
);
  import dds_pkg::*;

  `DDS_ASSERT_ALWAYS(a_rst_empty, rst |=> empty, "result pending after reset")
  `DDS_ASSERT(a_busy_after_accept, (push && !full) |=> full, "front idle after accept")
  `DDS_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(left_setpoint) && $stable(right_setpoint)), "result changed while waiting")
  `DDS_ASSERT(a_ratio_range, !empty |-> (left_ratio <= RATIO_ONE && right_ratio <= RATIO_ONE), "ratio above one")
endmodule

bind diff_drive_setpoint_shaper_top dds_checker u_dds_checker (.*);
`default_nettype wire
